// ===== hw/rtl/bc1_pkg.sv =====
// ----------------------------------------------------------------------------
// bc1_pkg
// shared types, constants and helper functions for the bc1 block decoder
// ----------------------------------------------------------------------------
package bc1_pkg;

    localparam int unsigned BLOCK_W     = 64;
    localparam int unsigned PIXEL_W     = 32;
    localparam int unsigned COLS        = 4;
    localparam int unsigned ROW_W       = 2;
    localparam int unsigned OUT_DATA_W  = 136;   // 4 pixels + row, padded to bytes
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned APB_ADDR_W  = 3;
    localparam int unsigned APB_DATA_W  = 32;

    // register index, taken from paddr[2]
    localparam logic REG_PUNCH_THROUGH = 1'b0;

    localparam logic [PIXEL_W-1:0] OPAQUE      = 32'hFF00_0000;
    localparam logic [PIXEL_W-1:0] TRANSPARENT = 32'h0000_0000;

    localparam logic [9:0]  RECIP3      = 10'd683;   // 2^11 / 3, rounded up
    localparam logic [2:0]  LAST_ROW    = 3'd3;

    typedef logic [PIXEL_W-1:0] t_pixel;

    // one decoded block: four palette entries and the 32 index bits
    typedef struct packed {
        t_pixel [3:0] pal;
        logic [31:0]  idx;
    } t_blk_entry;

    // queue head as seen by the back end
    typedef struct packed {
        logic       valid;
        t_blk_entry entry;
    } t_q_rd;

    // x / 3 for x < 768, via reciprocal multiply
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'(RECIP3);
        return p[18:11];
    endfunction

    function automatic t_pixel pack_rgb(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        return OPAQUE | {8'h00, r, g, b};
    endfunction

endpackage

// ===== hw/rtl/bc1_front.sv =====
// ----------------------------------------------------------------------------
// bc1_front
// accepts a compressed block, picks the palette mode and builds the palette
// ----------------------------------------------------------------------------
module bc1_front (
    input  logic                        i_valid,
    input  logic [bc1_pkg::BLOCK_W-1:0] i_block_bits,
    input  logic                        i_punch_through,
    input  logic                        i_q_full,
    output logic                        o_ready,
    output logic                        o_push,
    output bc1_pkg::t_blk_entry         o_entry
);

    logic [15:0] e0, e1;
    logic [7:0]  r0, g0, b0, r1, g1, b1;
    logic        four_color;

    assign e0 = i_block_bits[15:0];
    assign e1 = i_block_bits[31:16];

    // plain left shift, no bit replication
    assign r0 = {e0[15:11], 3'b000};
    assign g0 = {e0[10:5],  2'b00};
    assign b0 = {e0[4:0],   3'b000};
    assign r1 = {e1[15:11], 3'b000};
    assign g1 = {e1[10:5],  2'b00};
    assign b1 = {e1[4:0],   3'b000};

    assign four_color = (e0 > e1) || !i_punch_through;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        logic [8:0] sr, sg, sb;
        sr = 9'(r0) + 9'(r1);
        sg = 9'(g0) + 9'(g1);
        sb = 9'(b0) + 9'(b1);
        o_entry.idx    = i_block_bits[63:32];
        o_entry.pal[0] = bc1_pkg::pack_rgb(r0, g0, b0);
        o_entry.pal[1] = bc1_pkg::pack_rgb(r1, g1, b1);
        if (four_color) begin
            o_entry.pal[2] = bc1_pkg::pack_rgb(bc1_pkg::div3(10'(sr) + 10'(r0)),
                                               bc1_pkg::div3(10'(sg) + 10'(g0)),
                                               bc1_pkg::div3(10'(sb) + 10'(b0)));
            o_entry.pal[3] = bc1_pkg::pack_rgb(bc1_pkg::div3(10'(sr) + 10'(r1)),
                                               bc1_pkg::div3(10'(sg) + 10'(g1)),
                                               bc1_pkg::div3(10'(sb) + 10'(b1)));
        end else begin
            // truncated midpoint, then transparent black
            o_entry.pal[2] = bc1_pkg::pack_rgb(sr[8:1], sg[8:1], sb[8:1]);
            o_entry.pal[3] = bc1_pkg::TRANSPARENT;
        end
    end

endmodule

// ===== hw/rtl/bc1_queue.sv =====
// ----------------------------------------------------------------------------
// bc1_queue
// small fifo of decoded palettes between the front and back ends
// ----------------------------------------------------------------------------
module bc1_queue #(
    parameter int unsigned DEPTH = bc1_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  bc1_pkg::t_blk_entry i_entry,
    input  logic                i_pop,
    output bc1_pkg::t_q_rd      o_rd,
    output logic                o_full
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    bc1_pkg::t_blk_entry r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr_ptr, n_rd_ptr;
    logic [CW-1:0] n_count;

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_rd.valid   = (r_count != '0);
    assign o_rd.entry   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== hw/rtl/bc1_back.sv =====
// ----------------------------------------------------------------------------
// bc1_back
// walks the four rows of the head block and drives the output register
// ----------------------------------------------------------------------------
module bc1_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bc1_pkg::t_q_rd                 i_rd,
    output logic                           o_pop,
    output logic                           o_tvalid,
    input  logic                           i_tready,
    output logic [bc1_pkg::OUT_DATA_W-1:0] o_tdata,
    output logic                           o_tlast
);

    logic [bc1_pkg::ROW_W-1:0]  r_row, n_row;
    logic                       r_valid, n_valid;
    logic [bc1_pkg::OUT_DATA_W-1:0] r_data;
    logic                       r_last;
    logic                       adv;
    logic [7:0]                 row_idx;
    bc1_pkg::t_pixel [bc1_pkg::COLS-1:0] pix;

    assign adv     = i_rd.valid && (!r_valid || i_tready);
    assign o_pop   = adv && (r_row == bc1_pkg::LAST_ROW[bc1_pkg::ROW_W-1:0]);
    assign row_idx = i_rd.entry.idx[{r_row, 3'b000} +: 8];

    always_comb begin
        for (int c = 0; c < bc1_pkg::COLS; c++) begin
            pix[c] = i_rd.entry.pal[row_idx[2*c +: 2]];
        end
    end

    always_comb begin
        n_row   = adv ? r_row + 1'b1 : r_row;
        n_valid = adv ? 1'b1 : (i_tready ? 1'b0 : r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_data <= {6'b0, r_row, pix};
            r_last <= (r_row == bc1_pkg::LAST_ROW[bc1_pkg::ROW_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_row   <= n_row;
            r_valid <= n_valid;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tlast  = r_last;

endmodule

// ===== hw/rtl/bc1_block_decoder_core.sv =====
// ----------------------------------------------------------------------------
// bc1_block_decoder_core
// bc1 (dxt1) block decoder: one 8-byte block in, four pixel rows out
// ----------------------------------------------------------------------------
// an accepted block is written into the palette queue, and its rows are then
//   registered into the output register from the queue head, one row per cycle
//   while m_tready allows; the front takes a block per cycle while the
//   palette queue has room
// reset: i_rst_n synchronous active low; queue and output emptied, row counter
//   cleared, punch-through register set to 1
// ----------------------------------------------------------------------------
module bc1_block_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = bc1_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bc1_pkg::BLOCK_W-1:0]       s_tdata,   // [63:0] block_bits

    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] pixel_col0, [63:32] pixel_col1, [95:64] pixel_col2,
    // [127:96] pixel_col3, [129:128] row_number, [135:130] zero
    output logic [bc1_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tlast,   // last_row

    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bc1_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bc1_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bc1_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    // punch-through enable, reset to 1
    logic r_punch_through;
    logic cfg_wr;

    // front to queue
    logic                q_push;
    logic                q_full;
    bc1_pkg::t_blk_entry q_wr_entry;

    // queue to back
    bc1_pkg::t_q_rd      q_rd;
    logic                q_pop;

    // ------------------------------------------------------------------------
    // configuration: one register, word index in paddr[2]
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == bc1_pkg::REG_PUNCH_THROUGH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_punch_through <= 1'b1;
        end else if (cfg_wr) begin
            r_punch_through <= pwdata[0];
        end
    end

    // reads return the register at its address, zero elsewhere
    assign prdata = (paddr[2] == bc1_pkg::REG_PUNCH_THROUGH) ?
                    {{(bc1_pkg::APB_DATA_W-1){1'b0}}, r_punch_through} : '0;

    // ------------------------------------------------------------------------
    // front end: take a block, classify the mode, build the palette
    // ------------------------------------------------------------------------
    bc1_front u_front (
        .i_valid         (s_tvalid),
        .i_block_bits    (s_tdata),
        .i_punch_through (r_punch_through),
        .i_q_full        (q_full),
        .o_ready         (s_tready),
        .o_push          (q_push),
        .o_entry         (q_wr_entry)
    );

    // ------------------------------------------------------------------------
    // palette queue decouples accept from row emission
    // ------------------------------------------------------------------------
    bc1_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_wr_entry),
        .i_pop   (q_pop),
        .o_rd    (q_rd),
        .o_full  (q_full)
    );

    // ------------------------------------------------------------------------
    // back end: while m_tready allows, one row per cycle into the output register
    // ------------------------------------------------------------------------
    bc1_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd     (q_rd),
        .o_pop    (q_pop),
        .o_tvalid (m_tvalid),
        .i_tready (m_tready),
        .o_tdata  (m_tdata),
        .o_tlast  (m_tlast)
    );

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // tlast marks row 3 and nothing else
    a_last_is_row3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[129:128] == 2'd3)))
        else $error("tlast does not match row 3");

    // rows leave in order 0,1,2,3,0,...
    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tready) ##1 m_tvalid |->
            (m_tdata[129:128] == $past(m_tdata[129:128]) + 2'd1))
        else $error("row sequence broken");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
